// ===== rtl/core/hrf_pkg.sv =====
// package for the hex record framer: types, constants, microcode and helpers
package hrf_pkg;

    // default line length and configuration port widths
    localparam int LINE_BYTES_DEF = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 3;
    localparam int STEP_W         = 5;

    // ascii characters used in records
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    // input commands
    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_FLUSH    = 2'd1,
        CMD_SET_ADDR = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT_MODE = 2'd0,
        CFG_EMIT_ENABLE = 2'd1,
        CFG_BYTES_PER_A = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    // sequencer states
    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } t_seq_state;

    // character source of a microcode step
    typedef enum logic [2:0] {
        CS_COLON,
        CS_SPACE,
        CS_ZERO,
        CS_NEWLINE,
        CS_HI,
        CS_LO
    } t_csel;

    // byte source for hex digits and checksum
    typedef enum logic [2:0] {
        BS_COUNT,
        BS_ADDR_HI,
        BS_ADDR_LO,
        BS_DATA,
        BS_CKSUM
    } t_bsel;

    // jump condition
    typedef enum logic [1:0] {
        JC_NONE,
        JC_LIST,
        JC_MORE,
        JC_END
    } t_jcond;

    typedef logic [STEP_W-1:0] t_step;

    // one control word
    typedef struct packed {
        t_csel  csel;
        t_bsel  bsel;
        logic   sum_add;
        logic   k_inc;
        t_jcond jc;
        t_step  target;
    } t_uword;

    // status from the datapath back to the sequencer
    typedef struct packed {
        logic adv;
        logic more;
    } t_dp_stat;

    // jump targets
    localparam t_step ST_HEX_DATA   = 5'd9;
    localparam t_step ST_LIST_ADDR  = 5'd14;
    localparam t_step ST_LIST_SPACE = 5'd18;
    localparam t_step ST_ENTRY      = 5'd0;

    function automatic t_uword f_uw(t_csel c, t_bsel b, logic s, logic k,
                                    t_jcond j, t_step t);
        t_uword w;
        w.csel    = c;
        w.bsel    = b;
        w.sum_add = s;
        w.k_inc   = k;
        w.jc      = j;
        w.target  = t;
        return w;
    endfunction

    // microcode rom: every record starts at step 0; listing records jump to step 14 after the colon
    function automatic t_uword f_ucode(t_step s);
        t_uword w;
        unique case (s)
            5'd0:  w = f_uw(CS_COLON,   BS_COUNT,   1'b0, 1'b0, JC_LIST, ST_LIST_ADDR);
            5'd1:  w = f_uw(CS_HI,      BS_COUNT,   1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd2:  w = f_uw(CS_LO,      BS_COUNT,   1'b1, 1'b0, JC_NONE, ST_ENTRY);
            5'd3:  w = f_uw(CS_HI,      BS_ADDR_HI, 1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd4:  w = f_uw(CS_LO,      BS_ADDR_HI, 1'b1, 1'b0, JC_NONE, ST_ENTRY);
            5'd5:  w = f_uw(CS_HI,      BS_ADDR_LO, 1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd6:  w = f_uw(CS_LO,      BS_ADDR_LO, 1'b1, 1'b0, JC_NONE, ST_ENTRY);
            5'd7:  w = f_uw(CS_ZERO,    BS_COUNT,   1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd8:  w = f_uw(CS_ZERO,    BS_COUNT,   1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd9:  w = f_uw(CS_HI,      BS_DATA,    1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd10: w = f_uw(CS_LO,      BS_DATA,    1'b1, 1'b1, JC_MORE, ST_HEX_DATA);
            5'd11: w = f_uw(CS_HI,      BS_CKSUM,   1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd12: w = f_uw(CS_LO,      BS_CKSUM,   1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd13: w = f_uw(CS_NEWLINE, BS_COUNT,   1'b0, 1'b0, JC_END,  ST_ENTRY);
            5'd14: w = f_uw(CS_HI,      BS_ADDR_HI, 1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd15: w = f_uw(CS_LO,      BS_ADDR_HI, 1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd16: w = f_uw(CS_HI,      BS_ADDR_LO, 1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd17: w = f_uw(CS_LO,      BS_ADDR_LO, 1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd18: w = f_uw(CS_SPACE,   BS_DATA,    1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd19: w = f_uw(CS_HI,      BS_DATA,    1'b0, 1'b0, JC_NONE, ST_ENTRY);
            5'd20: w = f_uw(CS_LO,      BS_DATA,    1'b0, 1'b1, JC_MORE, ST_LIST_SPACE);
            5'd21: w = f_uw(CS_NEWLINE, BS_COUNT,   1'b0, 1'b0, JC_END,  ST_ENTRY);
            default: w = f_uw(CS_NEWLINE, BS_COUNT, 1'b0, 1'b0, JC_END,  ST_ENTRY);
        endcase
        return w;
    endfunction

    // lowercase hex digit
    function automatic logic [7:0] f_hex_digit(logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10) begin
            d = CH_ZERO + {4'b0, v};
        end else begin
            d = CH_LOWER_A + {4'b0, v} - 8'd10;
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/hrf_if.sv =====
// channel interfaces: input items, output characters, configuration writes
interface hrf_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [15:0] new_address;

    modport source (output valid, command, data_byte, new_address, input ready);
    modport sink   (input valid, command, data_byte, new_address, output ready);
endinterface

interface hrf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface hrf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [2:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/hrf_ram.sv =====
// generic single write port ram with registered read
module hrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/hrf_useq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
module hrf_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_list,
    input  hrf_pkg::t_dp_stat i_stat,
    output logic              o_busy,
    output hrf_pkg::t_uword   o_uword
);
    import hrf_pkg::*;

    t_seq_state r_state, n_state;
    t_step      r_step, n_step;
    t_uword     w_uw;

    assign w_uw = f_ucode(r_step);

    // next state and step
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    n_state = SQ_RUN;
                    n_step  = ST_ENTRY;
                end
            end
            SQ_RUN: begin
                if (i_stat.adv) begin
                    unique case (w_uw.jc)
                        JC_NONE: n_step = r_step + 1'b1;
                        JC_LIST: n_step = i_list ? w_uw.target : r_step + 1'b1;
                        JC_MORE: n_step = i_stat.more ? w_uw.target : r_step + 1'b1;
                        JC_END: begin
                            n_state = SQ_IDLE;
                            n_step  = ST_ENTRY;
                        end
                    endcase
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy  = (r_state == SQ_RUN);
        o_uword = w_uw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_step  <= ST_ENTRY;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end
endmodule

// ===== rtl/core/hrf_datapath.sv =====
// record datapath: byte index, checksum, character formation and output register
module hrf_datapath #(
    parameter int LINE_BYTES = hrf_pkg::LINE_BYTES_DEF,
    parameter int AW         = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1,
    parameter int CW         = $clog2(LINE_BYTES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_run,
    input  hrf_pkg::t_uword    i_uword,
    input  logic [CW-1:0]      i_rec_n,
    input  logic [15:0]        i_rec_addr,
    input  logic [7:0]         i_rdata,
    output logic [AW-1:0]      o_raddr,
    output hrf_pkg::t_dp_stat  o_stat,
    hrf_char_if.source         o_char
);
    import hrf_pkg::*;

    localparam int MW = (AW + 1 > CW) ? AW + 1 : CW;

    logic [AW-1:0] r_k, n_k;
    logic [7:0]    r_sum, n_sum;
    logic          r_ov, n_ov;
    logic [7:0]    r_char, n_char;
    logic          r_last, n_last;
    logic          w_adv;
    logic          w_step;
    logic [7:0]    w_byte;
    logic [7:0]    w_chr;

    // a step runs when the output register is free or draining
    assign w_adv  = !r_ov || o_char.ready;
    assign w_step = i_run && w_adv;

    // byte source
    always_comb begin
        unique case (i_uword.bsel)
            BS_COUNT:   w_byte = 8'(i_rec_n);
            BS_ADDR_HI: w_byte = i_rec_addr[15:8];
            BS_ADDR_LO: w_byte = i_rec_addr[7:0];
            BS_DATA:    w_byte = i_rdata;
            BS_CKSUM:   w_byte = 8'd0 - r_sum;
            default:    w_byte = i_rdata;
        endcase
    end

    // character source
    always_comb begin
        unique case (i_uword.csel)
            CS_COLON:   w_chr = CH_COLON;
            CS_SPACE:   w_chr = CH_SPACE;
            CS_ZERO:    w_chr = CH_ZERO;
            CS_NEWLINE: w_chr = CH_NEWLINE;
            CS_HI:      w_chr = f_hex_digit(w_byte[7:4]);
            CS_LO:      w_chr = f_hex_digit(w_byte[3:0]);
            default:    w_chr = CH_NEWLINE;
        endcase
    end

    // index, checksum and output register next values
    always_comb begin
        n_k    = r_k;
        n_sum  = r_sum;
        n_ov   = r_ov;
        n_char = r_char;
        n_last = r_last;
        if (o_char.valid && o_char.ready) begin
            n_ov = 1'b0;
        end
        if (i_start) begin
            n_k   = '0;
            n_sum = '0;
        end else if (w_step) begin
            if (i_uword.k_inc) begin
                n_k = r_k + 1'b1;
            end
            if (i_uword.sum_add) begin
                n_sum = r_sum + w_byte;
            end
            n_ov   = 1'b1;
            n_char = w_chr;
            n_last = (i_uword.jc == JC_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_sum  <= n_sum;
        r_char <= n_char;
        r_last <= n_last;
    end

    // ram is read at the next index so data is ready for the next step
    assign o_raddr     = n_k;
    assign o_stat.adv  = w_adv;
    assign o_stat.more = (MW'(r_k) + MW'(1)) < MW'(i_rec_n);

    assign o_char.valid     = r_ov;
    assign o_char.char_code = r_char;
    assign o_char.last_char = r_last;
endmodule

// ===== rtl/core/hex_record_framer_top.sv =====
// top level of the hex record framer: config, address state and record launch
//
//  channel  | modport | carries
//  ---------+---------+-------------------------------------------
//  i_item   | sink    | command, data_byte, new_address
//  o_char   | source  | char_code, last_char (one per transaction)
//  i_cfg    | sink    | index, data (format, emit enable, step size)
//
// an item that starts no record leaves i_item.ready high; a record of n bytes
// runs one microcode step per character: 12 + 2n characters in hex mode and
// 6 + 3n in listing mode, all through the single output character register.
// i_item.ready is low while a record is being sent; a stalled o_char holds
// the sequencer. reset is synchronous and clears control state; the line
// buffer holds no reset value and only written entries are ever read.
module hex_record_framer_top #(
    parameter int LINE_BYTES = hrf_pkg::LINE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrf_item_if.sink   i_item,
    hrf_char_if.source o_char,
    hrf_cfg_if.sink    i_cfg
);
    import hrf_pkg::*;

    localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int CW = $clog2(LINE_BYTES + 1);

    logic          r_format, n_format;
    logic          r_emit, n_emit;
    logic [2:0]    r_bpa, n_bpa;
    logic [CW-1:0] r_bc, n_bc;
    logic [15:0]   r_line_addr, n_line_addr;
    logic [15:0]   r_cur, n_cur;
    logic [2:0]    r_sub, n_sub;
    logic [CW-1:0] r_rec_n, n_rec_n;
    logic [15:0]   r_rec_addr, n_rec_addr;

    logic          w_acc;
    logic          w_start;
    logic          w_wr;
    logic [CW-1:0] w_bc1;
    logic [2:0]    w_step_size;
    logic          w_busy;
    t_uword        w_uword;
    t_dp_stat      w_stat;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    assign i_item.ready = !w_busy;
    assign i_cfg.ready  = 1'b1;
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_step_size  = (r_bpa == 3'd0) ? 3'd1 : r_bpa;
    assign w_wr         = r_emit && (r_bc < CW'(LINE_BYTES));
    assign w_bc1        = r_bc + CW'(w_wr);

    // configuration writes
    always_comb begin
        n_format = r_format;
        n_emit   = r_emit;
        n_bpa    = r_bpa;
        if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_FORMAT_MODE: n_format = i_cfg.data[0];
                CFG_EMIT_ENABLE: n_emit   = i_cfg.data[0];
                CFG_BYTES_PER_A: n_bpa    = i_cfg.data;
                default: ;
            endcase
        end
    end

    // command handling and record launch
    always_comb begin
        n_bc        = r_bc;
        n_line_addr = r_line_addr;
        n_cur       = r_cur;
        n_sub       = r_sub;
        n_rec_n     = r_rec_n;
        n_rec_addr  = r_rec_addr;
        w_start     = 1'b0;
        if (w_acc) begin
            unique case (t_cmd'(i_item.command))
                CMD_WRITE: begin
                    n_bc = w_bc1;
                    if (r_sub <= 3'd1) begin
                        n_cur = r_cur + 16'd1;
                        n_sub = w_step_size;
                    end else begin
                        n_sub = r_sub - 3'd1;
                    end
                    if (r_emit && (w_bc1 >= CW'(LINE_BYTES))) begin
                        w_start     = 1'b1;
                        n_rec_n     = w_bc1;
                        n_rec_addr  = r_line_addr;
                        n_bc        = '0;
                        n_line_addr = n_cur;
                    end
                end
                CMD_FLUSH: begin
                    if (r_emit) begin
                        w_start     = (r_bc != '0);
                        n_rec_n     = r_bc;
                        n_rec_addr  = r_line_addr;
                        n_bc        = '0;
                        n_line_addr = r_cur;
                    end
                end
                CMD_SET_ADDR: begin
                    if (r_emit) begin
                        w_start    = (r_bc != '0);
                        n_rec_n    = r_bc;
                        n_rec_addr = r_line_addr;
                        n_bc       = '0;
                    end
                    n_cur = i_item.new_address;
                    if (r_emit || (r_bc == '0)) begin
                        n_line_addr = i_item.new_address;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= 1'b1;
            r_emit      <= 1'b1;
            r_bpa       <= 3'd1;
            r_bc        <= '0;
            r_line_addr <= '0;
            r_cur       <= '0;
            r_sub       <= 3'd1;
        end else begin
            r_format    <= n_format;
            r_emit      <= n_emit;
            r_bpa       <= n_bpa;
            r_bc        <= n_bc;
            r_line_addr <= n_line_addr;
            r_cur       <= n_cur;
            r_sub       <= n_sub;
        end
    end

    // record snapshot
    always_ff @(posedge i_clk) begin
        r_rec_n    <= n_rec_n;
        r_rec_addr <= n_rec_addr;
    end

    // line buffer
    hrf_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES),
        .AW    (AW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (w_acc && (i_item.command == CMD_WRITE) && w_wr),
        .i_waddr (r_bc[AW-1:0]),
        .i_wdata (i_item.data_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hrf_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_list  (!r_format),
        .i_stat  (w_stat),
        .o_busy  (w_busy),
        .o_uword (w_uword)
    );

    hrf_datapath #(
        .LINE_BYTES (LINE_BYTES),
        .AW         (AW),
        .CW         (CW)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_run      (w_busy),
        .i_uword    (w_uword),
        .i_rec_n    (r_rec_n),
        .i_rec_addr (r_rec_addr),
        .i_rdata    (w_rdata),
        .o_raddr    (w_raddr),
        .o_stat     (w_stat),
        .o_char     (o_char)
    );
endmodule

// ===== rtl/core/hrf_checker.sv =====
// port level checks for the hex record framer, bound to the top level
module hrf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_item_valid,
    input logic       i_item_ready,
    input logic [1:0] i_item_command,
    input logic       i_char_valid,
    input logic       i_char_ready,
    input logic [7:0] i_char_code,
    input logic       i_char_last
);
    import hrf_pkg::*;

    // the record end marker is always a newline
    a_last_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_char_valid && i_char_last |-> i_char_code == CH_NEWLINE)
        else $error("last character is not a newline");

    // no new item is taken while a record is still in flight
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_char_valid && !i_char_last |-> !i_item_ready)
        else $error("input ready while a record is unfinished");

    // an unused command starts nothing
    a_unused_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && i_item_ready && (i_item_command == CMD_NONE) |=> i_item_ready)
        else $error("unused command made the block busy");

    // a stalled character holds
    a_char_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_char_valid && !i_char_ready |=>
            i_char_valid && $stable(i_char_code) && $stable(i_char_last))
        else $error("stalled character changed");
endmodule

bind hex_record_framer_top hrf_checker u_hrf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_item_valid   (i_item.valid),
    .i_item_ready   (i_item.ready),
    .i_item_command (i_item.command),
    .i_char_valid   (o_char.valid),
    .i_char_ready   (o_char.ready),
    .i_char_code    (o_char.char_code),
    .i_char_last    (o_char.last_char)
);

// ===== tb/hrf_record_checker.sv =====
// record checker: follows the item, character and config channels and predicts the record text
module hrf_record_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    hrf_item_if  item_bus,
    hrf_char_if  char_bus,
    hrf_cfg_if   cfg_bus,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hrf_pkg::*;

    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_record_char;

    // characters still owed by the block, oldest first
    t_record_char expected_text[$];

    // shadow configuration
    logic       hex_format;
    logic       emit_on;
    logic [2:0] addr_step;

    // shadow record state
    logic [7:0]  line_bytes [LINE_BYTES_DEF];
    logic [4:0]  pend_count;
    logic [15:0] line_addr;
    logic [15:0] cur_addr;
    logic [2:0]  sub_left;

    int errors = 0;
    int char_index = 0;

    assign o_errors = errors;

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTED) begin
            $display("[%0t] mismatch at character %0d: %s", $realtime, char_index, what);
        end
        errors++;
    endtask

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_LOWER_A + 8'(v) - 8'd10;
    endfunction

    task automatic push_char(input logic [7:0] c, input logic last);
        t_record_char rc;
        rc.code = c;
        rc.last = last;
        expected_text.push_back(rc);
    endtask

    task automatic push_hex(input logic [7:0] v);
        push_char(nibble_char(v[7:4]), 1'b0);
        push_char(nibble_char(v[3:0]), 1'b0);
    endtask

    // when emit is on, send out whatever is pending, then start a new line at the current address
    task automatic emit_record();
        logic [7:0] cksum;
        if (!emit_on) begin
            return;
        end
        if (pend_count != 5'd0) begin
            push_char(CH_COLON, 1'b0);
            if (hex_format) begin
                push_hex({3'b000, pend_count});
                push_hex(line_addr[15:8]);
                push_hex(line_addr[7:0]);
                push_char(CH_ZERO, 1'b0);
                push_char(CH_ZERO, 1'b0);
                cksum = {3'b000, pend_count} + line_addr[7:0] + line_addr[15:8];
                for (int k = 0; k < int'(pend_count); k++) begin
                    push_hex(line_bytes[k]);
                    cksum = cksum + line_bytes[k];
                end
                push_hex(8'd0 - cksum);
            end else begin
                push_hex(line_addr[15:8]);
                push_hex(line_addr[7:0]);
                for (int k = 0; k < int'(pend_count); k++) begin
                    push_char(CH_SPACE, 1'b0);
                    push_hex(line_bytes[k]);
                end
            end
            push_char(CH_NEWLINE, 1'b1);
        end
        pend_count = 5'd0;
        line_addr  = cur_addr;
    endtask

    // advance the shadow state for one accepted item
    task automatic predict_item(input t_cmd cmd, input logic [7:0] d, input logic [15:0] a);
        case (cmd)
            CMD_WRITE: begin
                if (emit_on && pend_count < 5'(LINE_BYTES_DEF)) begin
                    line_bytes[pend_count[3:0]] = d;
                    pend_count++;
                end
                if (sub_left <= 3'd1) begin
                    cur_addr = cur_addr + 16'd1;
                    sub_left = (addr_step == 3'd0) ? 3'd1 : addr_step;
                end else begin
                    sub_left--;
                end
                if (emit_on && pend_count >= 5'(LINE_BYTES_DEF)) begin
                    emit_record();
                end
            end
            CMD_FLUSH: begin
                emit_record();
            end
            CMD_SET_ADDR: begin
                emit_record();
                cur_addr = a;
                if (pend_count == 5'd0) begin
                    line_addr = a;
                end
            end
            default: begin
            end
        endcase
    endtask

    // watch all channels at the clock edge
    always @(posedge i_clk) begin
        t_record_char want;
        if (!i_rst_n) begin
            hex_format = 1'b1;
            emit_on    = 1'b1;
            addr_step  = 3'd1;
            pend_count = 5'd0;
            line_addr  = 16'd0;
            cur_addr   = 16'd0;
            sub_left   = 3'd1;
            expected_text.delete();
        end else begin
            // configuration write transaction
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_FORMAT_MODE: hex_format = cfg_bus.data[0];
                    CFG_EMIT_ENABLE: emit_on    = cfg_bus.data[0];
                    CFG_BYTES_PER_A: addr_step  = cfg_bus.data;
                    default: begin
                    end
                endcase
            end
            // input item transaction
            if (item_bus.valid && item_bus.ready) begin
                predict_item(t_cmd'(item_bus.command), item_bus.data_byte,
                             item_bus.new_address);
            end
            // output character transaction
            if (char_bus.valid && char_bus.ready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %02h", char_bus.char_code));
                end else begin
                    want = expected_text.pop_front();
                    if (char_bus.char_code !== want.code) begin
                        report_mismatch($sformatf("char_code %02h, want %02h",
                                                  char_bus.char_code, want.code));
                    end
                    if (char_bus.last_char !== want.last) begin
                        report_mismatch($sformatf("last_char %0b, want %0b",
                                                  char_bus.last_char, want.last));
                    end
                end
                char_index++;
            end
        end
        o_pending <= expected_text.size();
    end

endmodule

// ===== tb/testbench.sv =====
// top of the framer testbench: clock, reset, stimulus, receiver pacing and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 64;
    localparam int RX_HOLD      = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 43;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold_req = 1'b0;
    int errors;
    int pending;
    int cycle_count = 0;

    hrf_item_if item_ch ();
    hrf_char_if char_ch ();
    hrf_cfg_if  cfg_ch ();

    hex_record_framer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_char  (char_ch),
        .i_cfg   (cfg_ch)
    );

    hrf_record_checker record_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .item_bus  (item_ch),
        .char_bus  (char_ch),
        .cfg_bus   (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver pacing, with an occasional long hold-off
    initial begin : rx_pacing
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                char_ch.ready <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
            end
            char_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // offer one item and wait for its transaction
    task automatic send_item(input t_cmd cmd, input logic [7:0] d, input logic [15:0] a);
        while ($urandom_range(99) < tx_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.data_byte   <= d;
        item_ch.new_address <= a;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // stop sending until every expected character is out, then let the block settle
    task automatic wait_for_quiet();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one register write; valid stays high for a following write
    task automatic cfg_write(input t_cfg_idx idx, input logic [2:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic apply_setting(input logic hex_fmt, input logic emit, input logic [2:0] step);
        wait_for_quiet();
        cfg_write(CFG_UNUSED, 3'($urandom_range(7)));
        cfg_write(CFG_FORMAT_MODE, {2'b00, hex_fmt});
        cfg_write(CFG_EMIT_ENABLE, {2'b00, emit});
        cfg_write(CFG_BYTES_PER_A, step);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly byte writes, with flushes, address loads and the odd unused command
    task automatic random_item();
        int r;
        logic [15:0] a;
        r = $urandom_range(99);
        a = 16'($urandom);
        if ($urandom_range(9) == 0) begin
            a = ($urandom_range(1) == 0) ? 16'hffff : 16'h0000;
        end
        if (r < 72) begin
            send_item(CMD_WRITE, 8'($urandom), a);
        end else if (r < 84) begin
            send_item(CMD_FLUSH, 8'($urandom), a);
        end else if (r < 95) begin
            send_item(CMD_SET_ADDR, 8'($urandom), a);
        end else begin
            send_item(CMD_NONE, 8'($urandom), a);
        end
    endtask

    initial begin : stimulus
        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.command     <= CMD_WRITE;
        item_ch.data_byte   <= 8'h00;
        item_ch.new_address <= 16'h0000;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_FORMAT_MODE;
        cfg_ch.data         <= 3'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset settings: hex records, one byte per address
        tx_idle_pct = 33;
        rx_idle_pct = 53;
        send_item(CMD_WRITE, 8'h00, 16'h0000);
        send_item(CMD_WRITE, 8'hff, 16'hffff);
        send_item(CMD_FLUSH, 8'h00, 16'h0000);
        // flush with nothing pending
        send_item(CMD_FLUSH, 8'hff, 16'hffff);
        send_item(CMD_NONE, 8'hff, 16'hffff);
        // address load with a byte pending flushes it first
        send_item(CMD_WRITE, 8'ha5, 16'h0000);
        send_item(CMD_SET_ADDR, 8'h00, 16'hfff8);
        // full line closes itself while the address wraps
        for (int k = 0; k < LINE_BYTES_DEF; k++) begin
            send_item(CMD_WRITE, (k % 2 == 0) ? 8'h00 : 8'hff, 16'($urandom));
        end
        send_item(CMD_SET_ADDR, 8'h00, 16'h0000);

        // random phases, each preceded by its own setting write
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_setting(1'b1, 1'b1, 3'd1);
                1: apply_setting(1'b0, 1'b1, 3'd4);
                2: apply_setting(1'b1, 1'b1, 3'd0);
                3: apply_setting(1'b0, 1'b0, 3'd7);
                4: apply_setting(1'b1, 1'b1, 3'd7);
                5: apply_setting(1'b0, 1'b1, 3'd2);
                6: apply_setting(1'b1, 1'b0, 3'd3);
                default: apply_setting(1'b0, 1'b1, 3'd4);
            endcase
            if (ph < 3) begin
                tx_idle_pct = 33;
                rx_idle_pct = 53;
            end else if (ph < 6) begin
                tx_idle_pct = 53;
                rx_idle_pct = 33;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off so the block backs up onto its input
                if (ph == 1 && n == 8) begin
                    rx_hold_req = 1'b1;
                end
                // sender pause mid-phase
                if (ph == 5 && n == 23) begin
                    wait_for_quiet();
                end
                random_item();
            end
        end

        wait_for_quiet();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/hrf_pkg.sv
rtl/core/hrf_if.sv
rtl/core/hrf_ram.sv
rtl/core/hrf_useq.sv
rtl/core/hrf_datapath.sv
rtl/core/hex_record_framer_top.sv
rtl/core/hrf_checker.sv
tb/hrf_record_checker.sv
tb/testbench.sv
